// File: src/rbst_pkg.sv
// Shared types and constants for the ray versus unit-box slab test.
package rbst_pkg;

   localparam int COORD_W = 32;
   localparam int AXES    = 3;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic      ok;
      logic      out_of_slab;
      coord_type t_lo;
      coord_type t_hi;
   } axis_result_type;

endpackage

// File: src/rbst_divider.sv
// Pipelined signed restoring divider, one quotient bit per stage, saturated to 32 bits.
module rbst_divider
   import rbst_pkg::*;
#(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32
) (
   input  logic                    clock,
   input  logic                    advance,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [DEN_W-1:0] den,
   output coord_type               quo
);

   localparam int MAG_W = NUM_W;
   localparam int REM_W = DEN_W + 1;

   logic [MAG_W-1:0] q_ff   [0:NUM_W];
   logic [REM_W-1:0] r_ff   [0:NUM_W];
   logic [DEN_W-1:0] d_ff   [0:NUM_W];
   logic             neg_ff [0:NUM_W];
   coord_type        quo_ff;

   logic [MAG_W-1:0] num_mag;
   logic [DEN_W-1:0] den_mag;

   assign num_mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
   assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff[0]   <= num_mag;
         r_ff[0]   <= '0;
         d_ff[0]   <= den_mag;
         neg_ff[0] <= num[NUM_W-1] ^ den[DEN_W-1];
      end
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [REM_W-1:0] sh;
      logic [REM_W:0]   diff;
      assign sh   = {r_ff[s][REM_W-2:0], q_ff[s][MAG_W-1]};
      assign diff = {1'b0, sh} - {2'b00, d_ff[s]};
      always_ff @(posedge clock) begin
         if (advance) begin
            d_ff[s+1]   <= d_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            if (!diff[REM_W]) begin
               r_ff[s+1] <= diff[REM_W-1:0];
               q_ff[s+1] <= {q_ff[s][MAG_W-2:0], 1'b1};
            end else begin
               r_ff[s+1] <= sh;
               q_ff[s+1] <= {q_ff[s][MAG_W-2:0], 1'b0};
            end
         end
      end
   end

   logic [MAG_W-1:0] qm;
   logic             big;
   coord_type        quo_in;
   assign qm = q_ff[NUM_W];
   assign big = neg_ff[NUM_W] ? (qm > MAG_W'(64'h8000_0000))
                              : (qm > MAG_W'(64'h7FFF_FFFF));
   always_comb begin
      if (big)
         quo_in = neg_ff[NUM_W] ? coord_type'(32'h8000_0000) : coord_type'(32'h7FFF_FFFF);
      else
         quo_in = neg_ff[NUM_W] ? coord_type'(-qm[COORD_W-1:0]) : coord_type'(qm[COORD_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (advance) quo_ff <= quo_in;
   end
   assign quo = quo_ff;

endmodule

// File: src/rbst_axis.sv
// One axis of the slab test: two crossings through pipelined dividers, ordered.
module rbst_axis
   import rbst_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int LAT       = 66
) (
   input  logic            clock,
   input  logic            advance,
   input  coord_type       origin,
   input  coord_type       dir,
   output axis_result_type res
);

   localparam int NUM_W = COORD_W + 2 + FRAC_BITS;
   localparam logic signed [NUM_W-1:0] HALF = NUM_W'(1) <<< (FRAC_BITS - 1);

   logic signed [NUM_W-1:0] o_ext, num_a, num_b;
   logic                    zero, outside;
   coord_type               qa, qb;

   assign o_ext   = NUM_W'(origin);
   assign num_a   = (-HALF - o_ext) <<< FRAC_BITS;
   assign num_b   = (HALF - o_ext) <<< FRAC_BITS;
   assign zero    = (dir == '0);
   assign outside = (o_ext < -HALF) || (o_ext > HALF);

   rbst_divider #(.NUM_W(NUM_W), .DEN_W(COORD_W)) u_div_a (
      .clock(clock), .advance(advance), .num(num_a), .den(dir), .quo(qa));
   rbst_divider #(.NUM_W(NUM_W), .DEN_W(COORD_W)) u_div_b (
      .clock(clock), .advance(advance), .num(num_b), .den(dir), .quo(qb));

   logic [LAT-1:0] zero_ff, out_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff <= {zero_ff[LAT-2:0], zero};
         out_ff  <= {out_ff[LAT-2:0], zero & outside};
      end
   end

   always_comb begin
      res.ok          = !zero_ff[LAT-1];
      res.out_of_slab = out_ff[LAT-1];
      res.t_lo        = (qa > qb) ? qb : qa;
      res.t_hi        = (qa > qb) ? qa : qb;
   end

endmodule

// File: src/ray_unit_box_slab_test_unit.sv
// Top level of the pipelined ray versus unit-box slab test.
//
// Request channel: req_valid with origin and direction (signed fixed point,
// FRAC_BITS fraction bits) per axis; a transaction is taken when req_valid is
// high and req_stall low. Response channel: rsp_valid with rsp_hit, rsp_t_near,
// rsp_t_far; taken when rsp_valid is high and rsp_stall low.
// One transaction enters per cycle while req_stall is low. Each transaction passes
// through the bit-per-stage dividers (FRAC_BITS + 34 stages plus input and
// output registers) and the final fold register before rsp_valid.
// The whole pipeline advances together; when rsp_stall holds a valid response,
// the pipeline freezes and req_stall is raised, so nothing is lost or repeated.
// Bubbles do not freeze the pipeline. Reset clears all valid bits; payload
// registers are not reset. No configuration registers.
module ray_unit_box_slab_test_unit
   import rbst_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  coord_type req_origin_x,
   input  coord_type req_origin_y,
   input  coord_type req_origin_z,
   input  coord_type req_dir_x,
   input  coord_type req_dir_y,
   input  coord_type req_dir_z,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output logic      rsp_hit,
   output coord_type rsp_t_near,
   output coord_type rsp_t_far
);

   localparam int NUM_W = COORD_W + 2 + FRAC_BITS;
   localparam int LAT   = NUM_W + 2;
   localparam logic signed [63:0] LIM64 = 64'sd1000000 <<< FRAC_BITS;
   localparam coord_type T_INIT_FAR  = (LIM64 > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                                : COORD_W'(LIM64);
   localparam coord_type T_INIT_NEAR = (-LIM64 < -64'sh8000_0000) ? 32'sh8000_0000
                                                                  : COORD_W'(-LIM64);

   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   logic [LAT-1:0] v_ff;
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (advance) v_ff <= {v_ff[LAT-2:0], req_valid};
   end

   axis_result_type r [AXES];
   coord_type org [AXES];
   coord_type dir [AXES];
   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;
   assign dir[0] = req_dir_x;
   assign dir[1] = req_dir_y;
   assign dir[2] = req_dir_z;

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      rbst_axis #(.FRAC_BITS(FRAC_BITS), .LAT(LAT)) u_axis (
         .clock(clock), .advance(advance), .origin(org[a]), .dir(dir[a]), .res(r[a]));
   end

   coord_type n_in, f_in;
   logic      miss_in, hit_in;
   always_comb begin
      n_in    = T_INIT_NEAR;
      f_in    = T_INIT_FAR;
      miss_in = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         if (r[a].out_of_slab) miss_in = 1'b1;
         if (r[a].ok) begin
            if (r[a].t_lo > n_in) n_in = r[a].t_lo;
            if (r[a].t_hi < f_in) f_in = r[a].t_hi;
         end
      end
      hit_in = !miss_in && (n_in < f_in) && !n_in[COORD_W-1];
   end

   logic      rsp_valid_ff, hit_ff;
   coord_type near_ff, far_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= v_ff[LAT-1];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff  <= hit_in;
         near_ff <= miss_in ? '0 : n_in;
         far_ff  <= miss_in ? '0 : f_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = hit_ff;
   assign rsp_t_near = near_ff;
   assign rsp_t_far  = far_ff;

endmodule

// File: tb/sv/tb.sv
// Testbench for the ray versus unit-box slab test: directed and random rays.
`timescale 1ns / 100ps

module tb;
   import rbst_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = FRAC + 36;
   localparam longint HALF = 64'sd1 <<< (FRAC - 1);
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic      hit;
      coord_type t_near;
      coord_type t_far;
   } slab_result_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   coord_type req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   coord_type req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic      rsp_hit;
   coord_type rsp_t_near, rsp_t_far;

   slab_result_type pending_hits[$];
   int  errors = 0;
   int  cycles = 0;
   bit  idle_enable = 1'b1;
   int  hold_off = 0;

   ray_unit_box_slab_test_unit #(.FRAC_BITS(FRAC)) uut (.*);

   always #6 clock = ~clock;

   function automatic longint clamp32(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   function automatic slab_result_type slab_predict(coord_type o[3], coord_type d[3]);
      slab_result_type r;
      longint tn, tf, a, b, oo, dd, sw;
      tn = clamp32(-64'sd1000000 * (64'sd1 <<< FRAC));
      tf = clamp32(64'sd1000000 * (64'sd1 <<< FRAC));
      for (int i = 0; i < 3; i++) begin
         oo = o[i];
         dd = d[i];
         if (dd == 0) begin
            if (oo < -HALF || oo > HALF) begin
               r.hit = 1'b0;
               r.t_near = '0;
               r.t_far = '0;
               return r;
            end
            continue;
         end
         a = clamp32(((-HALF - oo) * (64'sd1 <<< FRAC)) / dd);
         b = clamp32(((HALF - oo) * (64'sd1 <<< FRAC)) / dd);
         if (a > b) begin
            sw = a; a = b; b = sw;
         end
         if (a > tn) tn = a;
         if (b < tf) tf = b;
      end
      r.hit = (tn < tf) && (tn >= 0);
      r.t_near = coord_type'(tn);
      r.t_far = coord_type'(tf);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[ray_unit_box_slab_test_unit] ERROR");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hits.size() == 0) begin
            report_mismatch("unexpected transaction", 0, 0);
         end else begin
            slab_result_type e;
            e = pending_hits.pop_front();
            if (rsp_hit !== e.hit) report_mismatch("hit", rsp_hit, e.hit);
            if (rsp_t_near !== e.t_near) report_mismatch("t_near", rsp_t_near, e.t_near);
            if (rsp_t_far !== e.t_far) report_mismatch("t_far", rsp_t_far, e.t_far);
         end
      end
   end

   // receiver stall: long hold-off or random bursts
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
            hold_off--;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 14);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_ray(coord_type o[3], coord_type d[3]);
      if (idle_enable && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_origin_x <= o[0]; req_origin_y <= o[1]; req_origin_z <= o[2];
      req_dir_x <= d[0]; req_dir_y <= d[1]; req_dir_z <= d[2];
      do @(posedge clock); while (req_stall);
      pending_hits = {pending_hits, slab_predict(o, d)};
      @(negedge clock);
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0: return coord_type'($urandom);
         1: return coord_type'(32'h8000_0000);
         2: return coord_type'(32'h7fff_ffff);
         3: return '0;
         4: return coord_type'($urandom_range(0, 2 * HALF) - HALF);
         default: return coord_type'(int'($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
      endcase
   endfunction

   task automatic send_random(int n);
      coord_type o[3], d[3];
      repeat (n) begin
         for (int i = 0; i < 3; i++) begin
            o[i] = rand_coord();
            d[i] = rand_coord();
         end
         send_ray(o, d);
      end
   endtask

   task automatic test_directed();
      coord_type o[3], d[3];
      coord_type ext[6];
      ext = '{32'h8000_0000, 32'h7fff_ffff, 0, coord_type'(HALF), coord_type'(-HALF), 1};
      foreach (ext[k]) begin
         o = '{ext[k], 0, 0}; d = '{coord_type'(1 << FRAC), 0, 0};
         send_ray(o, d);
         o = '{0, 0, 0}; d = '{ext[k], ext[k], ext[k]};
         send_ray(o, d);
      end
      o = '{coord_type'(HALF + 1), 0, 0}; d = '{0, 1, 1};           // parallel, outside
      send_ray(o, d);
      o = '{coord_type'(-HALF), coord_type'(HALF), 0}; d = '{0, 0, 5}; // parallel, on faces
      send_ray(o, d);
      o = '{0, 0, 0}; d = '{0, 0, 0};                                  // all axes skipped
      send_ray(o, d);
      o = '{coord_type'(-3 << FRAC), 0, 0}; d = '{coord_type'(1 << FRAC), 7, -7};
      send_ray(o, d);
      o = '{coord_type'(3 << FRAC), 0, 0}; d = '{coord_type'(1 << FRAC), 1, 1}; // behind
      send_ray(o, d);
   endtask

   task automatic test_backpressure();
      hold_off = 300;
      send_random(150);
   endtask

   task automatic test_drain_pause();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(negedge clock);
      send_random(50);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      send_random(1000);
      test_backpressure();
      test_drain_pause();
      idle_enable = 1'b0;
      send_random(300);
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (errors == 0)
         $display("[ray_unit_box_slab_test_unit] OK");
      else
         $display("[ray_unit_box_slab_test_unit] ERROR");
      $finish;
   end
endmodule

// File: filelist.f
src/rbst_pkg.sv
src/rbst_divider.sv
src/rbst_axis.sv
src/ray_unit_box_slab_test_unit.sv
tb/sv/tb.sv
